// ----- rtl/ltg_pkg.sv -----
// Shared widths, constants, types and the divider step for the triangle geometry pipeline.
package ltg_pkg;

	localparam int CRD_W     = 20;
	localparam int N_W       = CRD_W + 1;
	localparam int SUM_W     = CRD_W + 2;
	localparam int PROD_W    = 2 * N_W;
	localparam int DOT_W     = PROD_W + 1;
	localparam int MAG_W     = PROD_W;
	localparam int HALF_W    = (MAG_W + 1) / 2;
	localparam int SQ_W      = 2 * HALF_W;
	localparam int DET_W     = 44;
	localparam int AREA_W    = 43;
	localparam int GRAD_W    = 48;
	localparam int LANES     = 6;
	localparam int DEN_W     = 2 * MAG_W;
	localparam int REM_W     = DEN_W;
	localparam int Q_W       = GRAD_W + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int RQ_W      = Q_W + 1;
	localparam int CEN_T_W   = SUM_W + 1;
	localparam int CEN_SH    = 24;
	localparam int CEN_K_W   = CEN_SH - 1;
	localparam int CEN_P_W   = CEN_T_W + CEN_K_W;

	// ceil(2^24 / 3); exact for numerators below 2^23
	localparam logic [CEN_K_W-1:0] CEN_K = CEN_K_W'((2 ** CEN_SH + 2) / 3);

	localparam logic [RQ_W-1:0] GRAD_NEG_LIM = RQ_W'(1) << (GRAD_W - 1);
	localparam logic [RQ_W-1:0] GRAD_POS_LIM = GRAD_NEG_LIM - RQ_W'(1);

	// vertex pair of each dot product lane: AA, AB, AC, BB, BC, CC
	localparam int LANE_I [LANES] = '{0, 0, 0, 1, 1, 2};
	localparam int LANE_J [LANES] = '{0, 1, 2, 1, 2, 2};

	typedef struct packed {
		logic signed [DET_W-1:0]  det;
		logic signed [AREA_W-1:0] area;
		logic signed [CRD_W-1:0]  cx;
		logic signed [CRD_W-1:0]  cy;
		logic                     degen;
	} geo_side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic             qbit;
	} div_step_t;

	function automatic div_step_t div_step(input logic [REM_W-1:0] rem,
		input logic [DEN_W-1:0] den, input logic bit_in);
		logic [REM_W-1:0] sh;
		div_step_t        res;
		sh = {rem[REM_W-2:0], bit_in};
		if (sh >= den) begin
			res.rem  = sh - den;
			res.qbit = 1'b1;
		end else begin
			res.rem  = sh;
			res.qbit = 1'b0;
		end
		return res;
	endfunction

endpackage

// ----- rtl/ltg_in_if.sv -----
// Input channel: valid/ready with the three vertex coordinates.
interface ltg_in_if import ltg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CRD_W-1:0] a_x;
	logic signed [CRD_W-1:0] a_y;
	logic signed [CRD_W-1:0] b_x;
	logic signed [CRD_W-1:0] b_y;
	logic signed [CRD_W-1:0] c_x;
	logic signed [CRD_W-1:0] c_y;

	modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, input ready);
	modport sink (input valid, a_x, a_y, b_x, b_y, c_x, c_y, output ready);
	modport mon (input valid, ready, a_x, a_y, b_x, b_y, c_x, c_y);
endinterface

// ----- rtl/ltg_out_if.sv -----
// Output channel: valid/ready with the element geometry result.
interface ltg_out_if import ltg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DET_W-1:0]  jacobian_det;
	logic signed [AREA_W-1:0] signed_area;
	logic signed [CRD_W-1:0]  centroid_x;
	logic signed [CRD_W-1:0]  centroid_y;
	logic signed [GRAD_W-1:0] grad_aa;
	logic signed [GRAD_W-1:0] grad_ab;
	logic signed [GRAD_W-1:0] grad_ac;
	logic signed [GRAD_W-1:0] grad_bb;
	logic signed [GRAD_W-1:0] grad_bc;
	logic signed [GRAD_W-1:0] grad_cc;
	logic                     degenerate;

	modport source (output valid, jacobian_det, signed_area, centroid_x, centroid_y,
		grad_aa, grad_ab, grad_ac, grad_bb, grad_bc, grad_cc, degenerate, input ready);
	modport sink (input valid, jacobian_det, signed_area, centroid_x, centroid_y,
		grad_aa, grad_ab, grad_ac, grad_bb, grad_bc, grad_cc, degenerate, output ready);
	modport mon (input valid, ready, jacobian_det, signed_area, centroid_x, centroid_y,
		grad_aa, grad_ab, grad_ac, grad_bb, grad_bc, grad_cc, degenerate);
endinterface

// ----- rtl/linear_triangle_element_geometry.sv -----
// Top level: pipelined P1 triangle Jacobian, area, centroid and gradient dot products.
//
//  channel  | dir | handshake    | payload
//  tri_in   | in  | valid/ready  | a_x a_y b_x b_y c_x c_y
//  geo_out  | out | valid/ready  | jacobian_det signed_area centroid_x/y grad_* degenerate
//
// One triangle per cycle while the output is not stalled.
// The depth is set by the six restoring dividers, one quotient bit per stage over 49 stages.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears the valid bits only; no clearing pass.
module linear_triangle_element_geometry import ltg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ltg_in_if.sink     tri_in,
	ltg_out_if.source  geo_out
);

	logic adv;
	assign adv          = !geo_out.valid || geo_out.ready;
	assign tri_in.ready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic v_sdv [DIV_STEPS+1];

	// stage 1: basis numerator vectors and coordinate sums
	logic signed [N_W-1:0]   nx_s1 [3];
	logic signed [N_W-1:0]   ny_s1 [3];
	logic signed [SUM_W-1:0] sum_s1 [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1[0]  <= N_W'(tri_in.b_y) - N_W'(tri_in.c_y);
			ny_s1[0]  <= N_W'(tri_in.c_x) - N_W'(tri_in.b_x);
			nx_s1[1]  <= N_W'(tri_in.c_y) - N_W'(tri_in.a_y);
			ny_s1[1]  <= N_W'(tri_in.a_x) - N_W'(tri_in.c_x);
			nx_s1[2]  <= N_W'(tri_in.a_y) - N_W'(tri_in.b_y);
			ny_s1[2]  <= N_W'(tri_in.b_x) - N_W'(tri_in.a_x);
			sum_s1[0] <= SUM_W'(tri_in.a_x) + SUM_W'(tri_in.b_x) + SUM_W'(tri_in.c_x);
			sum_s1[1] <= SUM_W'(tri_in.a_y) + SUM_W'(tri_in.b_y) + SUM_W'(tri_in.c_y);
		end
	end

	// stage 2: products
	logic signed [PROD_W-1:0]  dp_s2 [LANES][2];
	logic signed [PROD_W-1:0]  dt_s2 [2];
	logic [CEN_P_W-1:0]        cp_s2 [2];
	logic                      cneg_s2 [2];
	logic [CEN_T_W-1:0]        ct [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			ct[k] = (sum_s1[k][SUM_W-1] ? CEN_T_W'(-sum_s1[k]) : CEN_T_W'(sum_s1[k]))
				+ CEN_T_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < LANES; g++) begin
				dp_s2[g][0] <= nx_s1[LANE_I[g]] * nx_s1[LANE_J[g]];
				dp_s2[g][1] <= ny_s1[LANE_I[g]] * ny_s1[LANE_J[g]];
			end
			dt_s2[0] <= ny_s1[2] * nx_s1[1];
			dt_s2[1] <= ny_s1[1] * nx_s1[2];
			for (int k = 0; k < 2; k++) begin
				cp_s2[k]   <= CEN_P_W'(ct[k]) * CEN_P_W'(CEN_K);
				cneg_s2[k] <= sum_s1[k][SUM_W-1];
			end
		end
	end

	// stage 3: determinant, dot products, centroid
	logic signed [DET_W-1:0] det_s3;
	logic signed [DOT_W-1:0] dot_s3 [LANES];
	logic signed [CRD_W-1:0] cen_s3 [2];
	logic [CRD_W-1:0]        cq [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			cq[k] = cp_s2[k][CEN_SH +: CRD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s3 <= DET_W'(dt_s2[0]) - DET_W'(dt_s2[1]);
			for (int g = 0; g < LANES; g++) begin
				dot_s3[g] <= DOT_W'(dp_s2[g][0]) + DOT_W'(dp_s2[g][1]);
			end
			for (int k = 0; k < 2; k++) begin
				cen_s3[k] <= cneg_s2[k] ? CRD_W'(0) - cq[k] : cq[k];
			end
		end
	end

	// stage 4: magnitudes, area, partial squares of |det|
	geo_side_t               side_s4;
	logic [MAG_W-1:0]        mag_s4 [LANES];
	logic                    neg_s4 [LANES];
	logic [SQ_W-1:0]         hh_s4, hl_s4, ll_s4;
	logic signed [DET_W-1:0] dadj;
	logic [MAG_W-1:0]        md;
	logic [HALF_W-1:0]       md_hi, md_lo;

	always_comb begin
		dadj  = det_s3 + $signed({{(DET_W-1){1'b0}}, det_s3[DET_W-1]});
		md    = det_s3[DET_W-1] ? MAG_W'(-det_s3) : MAG_W'(det_s3);
		md_hi = HALF_W'(md >> HALF_W);
		md_lo = md[HALF_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.det   <= det_s3;
			side_s4.area  <= AREA_W'(dadj >>> 1);
			side_s4.cx    <= cen_s3[0];
			side_s4.cy    <= cen_s3[1];
			side_s4.degen <= (det_s3 == '0);
			for (int g = 0; g < LANES; g++) begin
				neg_s4[g] <= dot_s3[g][DOT_W-1];
				mag_s4[g] <= dot_s3[g][DOT_W-1] ? MAG_W'(-dot_s3[g]) : MAG_W'(dot_s3[g]);
			end
			hh_s4 <= SQ_W'(md_hi) * SQ_W'(md_hi);
			hl_s4 <= SQ_W'(md_hi) * SQ_W'(md_lo);
			ll_s4 <= SQ_W'(md_lo) * SQ_W'(md_lo);
		end
	end

	// stage 5: det squared
	geo_side_t        side_s5;
	logic [MAG_W-1:0] mag_s5 [LANES];
	logic             neg_s5 [LANES];
	logic [DEN_W-1:0] den_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			den_s5  <= (DEN_W'(hh_s4) << (2 * HALF_W)) + (DEN_W'(hl_s4) << (HALF_W + 1))
				+ DEN_W'(ll_s4);
		end
	end

	// divider pipeline; index 0 is the set-up stage
	geo_side_t        side_sdv [DIV_STEPS+1];
	logic [DEN_W-1:0] den_sdv  [DIV_STEPS+1];
	logic [REM_W-1:0] rem_sdv  [DIV_STEPS+1][LANES];
	logic [Q_W-1:0]   quo_sdv  [DIV_STEPS+1][LANES];
	logic             neg_sdv  [DIV_STEPS+1][LANES];
	logic             ovf_sdv  [DIV_STEPS+1][LANES];
	logic             lsb_s6   [LANES];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sdv[0] <= side_s5;
			den_sdv[0]  <= den_s5;
			for (int g = 0; g < LANES; g++) begin
				ovf_sdv[0][g] <= (DEN_W'(mag_s5[g]) + DEN_W'(0)) >= {den_s5[DEN_W-2:0], 1'b0}
					|| den_s5[DEN_W-1];
				rem_sdv[0][g] <= REM_W'(mag_s5[g] >> 1);
				quo_sdv[0][g] <= '0;
				neg_sdv[0][g] <= neg_s5[g];
				lsb_s6[g]     <= mag_s5[g][0];
			end
		end
	end

	for (genvar d = 1; d <= DIV_STEPS; d++) begin : g_div
		div_step_t st [LANES];

		always_comb begin
			for (int g = 0; g < LANES; g++) begin
				st[g] = div_step(rem_sdv[d-1][g], den_sdv[d-1], (d == 1) ? lsb_s6[g] : 1'b0);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_sdv[d] <= side_sdv[d-1];
				den_sdv[d]  <= den_sdv[d-1];
				for (int g = 0; g < LANES; g++) begin
					rem_sdv[d][g] <= st[g].rem;
					quo_sdv[d][g] <= {quo_sdv[d-1][g][Q_W-2:0], st[g].qbit};
					neg_sdv[d][g] <= neg_sdv[d-1][g];
					ovf_sdv[d][g] <= ovf_sdv[d-1][g];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sdv[d] <= 1'b0;
			end else if (adv) begin
				v_sdv[d] <= v_sdv[d-1];
			end
		end
	end

	// rounding, saturation, sign and clearing of degenerate gradients
	logic [RQ_W-1:0]          qr  [LANES];
	logic [RQ_W-1:0]          lim [LANES];
	logic [RQ_W-1:0]          qs  [LANES];
	logic signed [GRAD_W-1:0] gv  [LANES];

	always_comb begin
		for (int g = 0; g < LANES; g++) begin
			qr[g]  = RQ_W'(quo_sdv[DIV_STEPS][g])
				+ RQ_W'({rem_sdv[DIV_STEPS][g], 1'b0} >= {1'b0, den_sdv[DIV_STEPS]});
			lim[g] = neg_sdv[DIV_STEPS][g] ? GRAD_NEG_LIM : GRAD_POS_LIM;
			qs[g]  = (ovf_sdv[DIV_STEPS][g] || qr[g] > lim[g]) ? lim[g] : qr[g];
			if (side_sdv[DIV_STEPS].degen) begin
				gv[g] = '0;
			end else if (neg_sdv[DIV_STEPS][g]) begin
				gv[g] = GRAD_W'(0) - qs[g][GRAD_W-1:0];
			end else begin
				gv[g] = qs[g][GRAD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_out.jacobian_det <= side_sdv[DIV_STEPS].det;
			geo_out.signed_area  <= side_sdv[DIV_STEPS].area;
			geo_out.centroid_x   <= side_sdv[DIV_STEPS].cx;
			geo_out.centroid_y   <= side_sdv[DIV_STEPS].cy;
			geo_out.degenerate   <= side_sdv[DIV_STEPS].degen;
			geo_out.grad_aa      <= gv[0];
			geo_out.grad_ab      <= gv[1];
			geo_out.grad_ac      <= gv[2];
			geo_out.grad_bb      <= gv[3];
			geo_out.grad_bc      <= gv[4];
			geo_out.grad_cc      <= gv[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			v_s5          <= 1'b0;
			v_sdv[0]      <= 1'b0;
			geo_out.valid <= 1'b0;
		end else if (adv) begin
			v_s1          <= tri_in.valid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			v_s4          <= v_s3;
			v_s5          <= v_s4;
			v_sdv[0]      <= v_s5;
			geo_out.valid <= v_sdv[DIV_STEPS];
		end
	end

endmodule

// ----- rtl/ltg_checker.sv -----
// Port checker for the triangle geometry pipeline, bound to the top level.
module ltg_checker import ltg_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     valid,
	input logic                     ready,
	input logic signed [DET_W-1:0]  jacobian_det,
	input logic signed [AREA_W-1:0] signed_area,
	input logic signed [GRAD_W-1:0] grad_aa,
	input logic signed [GRAD_W-1:0] grad_ab,
	input logic signed [GRAD_W-1:0] grad_ac,
	input logic signed [GRAD_W-1:0] grad_bb,
	input logic signed [GRAD_W-1:0] grad_bc,
	input logic signed [GRAD_W-1:0] grad_cc,
	input logic                     degenerate
);

	a_degen_det: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> degenerate == (jacobian_det == '0))
		else $error("degenerate flag disagrees with determinant");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && degenerate |-> grad_aa == '0 && grad_ab == '0
			&& grad_ac == '0 && grad_bb == '0 && grad_bc == '0
			&& grad_cc == '0)
		else $error("gradients not cleared on degenerate triangle");

	a_self_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !grad_aa[GRAD_W-1] && !grad_bb[GRAD_W-1] && !grad_cc[GRAD_W-1])
		else $error("squared gradient norm negative");

	a_area_sign: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> signed_area == '0 || signed_area[AREA_W-1] == jacobian_det[DET_W-1])
		else $error("area sign differs from determinant sign");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(jacobian_det) && $stable(grad_ab))
		else $error("stalled result changed");

endmodule

bind linear_triangle_element_geometry ltg_checker u_ltg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (geo_out.valid),
	.ready        (geo_out.ready),
	.jacobian_det (geo_out.jacobian_det),
	.signed_area  (geo_out.signed_area),
	.grad_aa      (geo_out.grad_aa),
	.grad_ab      (geo_out.grad_ab),
	.grad_ac      (geo_out.grad_ac),
	.grad_bb      (geo_out.grad_bb),
	.grad_bc      (geo_out.grad_bc),
	.grad_cc      (geo_out.grad_cc),
	.degenerate   (geo_out.degenerate)
);
